[sv/opp_pkg.sv]
// opp_pkg: shared constants for the onset peak picker.
// Holds configuration register indexes, field widths and reset values.
// No dependencies; compiled first.
package opp_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_BITS = 8;
	localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_OFFSET = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HOLDOFF_FRAMES   = 8'd1;

	// register widths and reset values
	localparam int unsigned OFFSET_BITS = 16;
	localparam int unsigned HOLD_BITS   = 4;
	localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 16'd13107; // 0.2 in Q0.16
	localparam logic [HOLD_BITS-1:0]   HOLD_RESET   = 4'd3;

	// five-value window around the decided frame, centre at index 2
	localparam int unsigned WIN_LEN = 5;
	localparam int unsigned WIN_MID = 2;

endpackage

[sv/opp_decide.sv]
// opp_decide: peak test for one five-value window (local max and median threshold).
// Purely combinational; uses opp_pkg for window length and offset width.
module opp_decide #(
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic [opp_pkg::WIN_LEN-1:0][VALUE_BITS-1:0] win,
	input  logic [opp_pkg::OFFSET_BITS-1:0]             threshold_offset,
	output logic                                        pass
);

	localparam int unsigned SUM_W =
		((VALUE_BITS > opp_pkg::OFFSET_BITS) ? VALUE_BITS : opp_pkg::OFFSET_BITS) + 1;

	logic [2:0]            rank [opp_pkg::WIN_LEN];
	logic [VALUE_BITS-1:0] med;
	logic [SUM_W-1:0]      thr_sum;
	logic [VALUE_BITS-1:0] c;

	// rank with ties broken by position; exactly one element has rank 2
	always_comb begin
		for (int i = 0; i < opp_pkg::WIN_LEN; i++) begin
			rank[i] = 3'd0;
			for (int j = 0; j < opp_pkg::WIN_LEN; j++) begin
				if (j != i) begin
					if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
						rank[i] = rank[i] + 3'd1;
					end
				end
			end
		end
		med = '0;
		for (int i = 0; i < opp_pkg::WIN_LEN; i++) begin
			if (rank[i] == 3'(opp_pkg::WIN_MID)) begin
				med = med | win[i];
			end
		end
	end

	assign c       = win[opp_pkg::WIN_MID];
	assign thr_sum = SUM_W'(med) + SUM_W'(threshold_offset);
	assign pass    = (c > win[opp_pkg::WIN_MID-1]) && (c > win[opp_pkg::WIN_MID+1]) &&
	                 (SUM_W'(c) > thr_sum);

endmodule

[sv/onset_peak_picker.sv]
// onset_peak_picker: one decision per frame, two frames late; 1 frame/cycle sustained when
// out_stall is low. A decision is computed from the input register into the output register.
// An end-of-stream frame holds the input register until its 1 to 3 flushed decisions are out.
// Reset (arst_n low, async) clears window, counters, holdoff and handshakes;
// threshold_offset returns to 13107 and holdoff_frames to 3. Uses opp_pkg and opp_decide.
module onset_peak_picker #(
	parameter int unsigned VALUE_BITS = 16,
	parameter int unsigned INDEX_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// frame input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [VALUE_BITS-1:0]              novelty_value,
	input  logic                               end_of_stream,
	// decision output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               is_peak,
	output logic [INDEX_BITS-1:0]              frame_index,
	output logic                               last_decision,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [opp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [opp_pkg::OFFSET_BITS-1:0]    cfg_data
);

	// configuration registers
	logic [opp_pkg::OFFSET_BITS-1:0] thr_q;
	logic [opp_pkg::HOLD_BITS-1:0]   hold_cfg_q;

	// input register (one frame request)
	logic                  valid_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic                  eos_s1;

	// sequence state: four previous values, oldest at index 0
	logic [VALUE_BITS-1:0]         win_q [4];
	logic [INDEX_BITS-1:0]         frames_q;   // index of next decided frame
	logic [opp_pkg::HOLD_BITS-1:0] holdoff_q;  // frames still suppressed
	logic [1:0]                    fill_q;     // warm-up count, 0..2
	logic [1:0]                    flush_k_q;  // decisions already flushed for the eos frame

	// output register
	logic                  out_valid_q;
	logic                  is_peak_q;
	logic [INDEX_BITS-1:0] frame_index_q;
	logic                  last_q;

	logic [opp_pkg::WIN_LEN-1:0][VALUE_BITS-1:0] win_sel;
	logic [1:0] centre_off;
	logic       needs_result;
	logic       out_free;
	logic       emit;
	logic       last_emit;
	logic       done;
	logic       pass;
	logic       peak;

	assign cfg_ready = 1'b1;

	// The window is (w0 w1 w2 w3 x 0 0); a normal frame decides at offset 0.
	// On end of stream the pending frames are decided oldest first, and the
	// offset walks up to 2 so that the trailing zeros pad the window.
	assign centre_off   = 2'd2 - fill_q + flush_k_q;
	assign needs_result = eos_s1 || (fill_q == 2'd2);
	assign out_free     = !out_valid_q || !out_stall;
	assign emit         = valid_s1 && needs_result && out_free;
	assign last_emit    = !eos_s1 || (centre_off == 2'd2);
	assign done         = valid_s1 && (!needs_result || (out_free && last_emit));
	assign in_stall     = valid_s1 && !done;

	always_comb begin
		case (centre_off)
			2'd1: begin
				win_sel = {{VALUE_BITS{1'b0}}, value_s1, win_q[3], win_q[2], win_q[1]};
			end
			2'd2: begin
				win_sel = {{VALUE_BITS{1'b0}}, {VALUE_BITS{1'b0}}, value_s1, win_q[3], win_q[2]};
			end
			default: begin
				win_sel = {value_s1, win_q[3], win_q[2], win_q[1], win_q[0]};
			end
		endcase
	end

	opp_decide #(
		.VALUE_BITS(VALUE_BITS)
	) u_decide (
		.win             (win_sel),
		.threshold_offset(thr_q),
		.pass            (pass)
	);

	// holdoff wins over the peak test
	assign peak = (holdoff_q == '0) && pass;

	// configuration; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= opp_pkg::OFFSET_RESET;
			hold_cfg_q <= opp_pkg::HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				opp_pkg::REG_THRESHOLD_OFFSET: thr_q      <= cfg_data;
				opp_pkg::REG_HOLDOFF_FRAMES:   hold_cfg_q <= cfg_data[opp_pkg::HOLD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			value_s1 <= novelty_value;
			eos_s1   <= end_of_stream;
		end
	end

	// sequence state; the end-of-stream clear comes last and overrides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				win_q[i] <= '0;
			end
			frames_q  <= '0;
			holdoff_q <= '0;
			fill_q    <= 2'd0;
			flush_k_q <= 2'd0;
		end else begin
			if (emit) begin
				if (holdoff_q != '0) begin
					holdoff_q <= holdoff_q - opp_pkg::HOLD_BITS'(1);
				end else if (pass) begin
					holdoff_q <= hold_cfg_q;
				end
				if (frames_q != '1) begin
					frames_q <= frames_q + INDEX_BITS'(1);
				end
			end
			if (done) begin
				if (eos_s1) begin
					for (int i = 0; i < 4; i++) begin
						win_q[i] <= '0;
					end
					frames_q  <= '0;
					holdoff_q <= '0;
					fill_q    <= 2'd0;
					flush_k_q <= 2'd0;
				end else begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2] <= win_q[3];
					win_q[3] <= value_s1;
					if (fill_q != 2'd2) begin
						fill_q <= fill_q + 2'd1;
					end
				end
			end else if (emit) begin
				flush_k_q <= flush_k_q + 2'd1;
			end
		end
	end

	// output register: refills in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			is_peak_q     <= peak;
			frame_index_q <= frames_q;
			last_q        <= eos_s1 && last_emit;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_peak       = is_peak_q;
	assign frame_index   = frame_index_q;
	assign last_decision = last_q;

	// checks on internal sequencing
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("warm-up count out of range");

	a_flush_only_eos: assert property (@(posedge clk) disable iff (!arst_n)
		(flush_k_q != 2'd0) |-> (valid_s1 && eos_s1 && (flush_k_q <= fill_q)))
		else $error("flush counter running outside an end-of-stream frame");

	a_peak_arms_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && peak && !eos_s1 && (hold_cfg_q != '0)) |=> (holdoff_q != '0))
		else $error("peak did not start holdoff");

endmodule
